// ----- design/priority_timeslice_dispatcher_assert.svh -----
// Assertion macros for the priority time-slice dispatcher.
// Used by priority_timeslice_dispatcher.sv; expects i_clk and i_rst_n in scope.
`ifndef PRIORITY_TIMESLICE_DISPATCHER_ASSERT_SVH
`define PRIORITY_TIMESLICE_DISPATCHER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define PTD_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define PTD_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- design/ptd_pkg.sv -----
// Shared types and codes for the priority time-slice dispatcher.
// No dependencies; used by priority_timeslice_dispatcher.sv.
package ptd_pkg;

    // Queue entry: id, priority, non-real-time flag, burst, service so far
    typedef struct packed {
        logic [9:0] id;
        logic [7:0] pr;
        logic       nrt;
        logic [7:0] bt;
        logic [7:0] served;
    } t_entry;

    // Result kinds
    localparam logic [1:0] KIND_DISPATCH = 2'd0;
    localparam logic [1:0] KIND_FINISHED = 2'd1;
    localparam logic [1:0] KIND_REQUEUED = 2'd2;
    localparam logic [1:0] KIND_DROPPED  = 2'd3;

    // Input operation codes
    localparam logic FUNC_ARRIVE    = 1'b0;
    localparam logic FUNC_SLICE_END = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_RT_QUANTUM  = 2'd0;
    localparam logic [1:0] CFG_NRT_QUANTUM = 2'd1;
    localparam logic [1:0] CFG_NRT_PENALTY = 2'd2;

    // Configuration reset values
    localparam logic [7:0] RT_QUANTUM_RST  = 8'd30;
    localparam logic [7:0] NRT_QUANTUM_RST = 8'd10;
    localparam logic [7:0] NRT_PENALTY_RST = 8'd5;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_EMIT,
        ST_CHECK,
        ST_POP_RD,
        ST_POP_DATA
    } t_state;

endpackage

// ----- design/priority_timeslice_dispatcher.sv -----
// Top level of the priority time-slice dispatcher: sequencer, queue memory, config.
// Depends on ptd_pkg.sv and priority_timeslice_dispatcher_assert.svh.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-----------------------------------
//  command  | in        | start, busy                | i_func i_task_id i_priority_req
//           |           |                            | i_is_nonrt i_burst
//  result   | out       | o_valid (one-cycle strobe) | o_kind o_out_task o_slice_len o_last
//  config   | in        | i_cfg_valid, o_cfg_ready   | i_cfg_index i_cfg_data
//
// A command keeps busy high while the sorted insert walks down the queue, each
// shifted entry (fewer than QUEUE_DEPTH) read from the queue memory and then
// compared, and through the emit, check and pop states after it; commands with
// no insert keep busy high only for the emit, check and pop states they take.
// Reset is synchronous, active low; queue contents are not cleared (counts are).
// Results cannot be stalled; busy falls no earlier than the cycle of the last result.
module priority_timeslice_dispatcher #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_func,
    input  logic [9:0] i_task_id,
    input  logic [7:0] i_priority_req,
    input  logic       i_is_nonrt,
    input  logic [7:0] i_burst,
    output logic       o_valid,
    output logic [1:0] o_kind,
    output logic [9:0] o_out_task,
    output logic [7:0] o_slice_len,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int AW = $clog2(2 * QUEUE_DEPTH);
    localparam int PW = AW + 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
    localparam logic [IW-1:0] HEAD_LAST = IW'(QUEUE_DEPTH - 1);

    // Physical address of logical slot j in bank b (circular from the bank head)
    function automatic logic [AW-1:0] f_addr(input logic b, input logic [CW-1:0] j,
                                             input logic [IW-1:0] h);
        logic [PW-1:0] s;
        s = PW'(h) + PW'(j);
        if (s >= PW'(QUEUE_DEPTH)) s = s - PW'(QUEUE_DEPTH);
        if (b) s = s + PW'(QUEUE_DEPTH);
        return AW'(s);
    endfunction

    ptd_pkg::t_state r_state, n_state;

    // Queue memory, both banks
    ptd_pkg::t_entry mem [2*QUEUE_DEPTH];
    ptd_pkg::t_entry r_rdata;
    logic            w_we;
    logic [AW-1:0]   w_waddr, w_raddr;
    ptd_pkg::t_entry w_wdata;

    // Control state
    logic            r_act, n_act;
    logic [CW-1:0]   r_cnt [2];
    logic [CW-1:0]   n_cnt [2];
    logic [IW-1:0]   r_head [2];
    logic [IW-1:0]   n_head [2];
    logic            r_run, n_run;
    ptd_pkg::t_entry r_running, n_running;

    // Command context
    logic            r_func, n_func;
    ptd_pkg::t_entry r_ent, n_ent;
    logic            r_ins_bank, n_ins_bank;
    logic [CW-1:0]   r_j, n_j;
    logic            r_has_res, n_has_res;
    logic [1:0]      r_res_kind, n_res_kind;
    logic [9:0]      r_res_task, n_res_task;

    // Result register
    logic            r_o_valid, n_o_valid;
    logic [1:0]      r_o_kind, n_o_kind;
    logic [9:0]      r_o_task, n_o_task;
    logic [7:0]      r_o_slice, n_o_slice;
    logic            r_o_last, n_o_last;

    // Configuration
    logic [7:0]      r_rt_q, r_nrt_q, r_nrt_pen;

    // Helpers
    logic            w_disp;
    logic [8:0]      w_pen_sum;
    logic [7:0]      w_rem, w_quant, w_slice;

    assign busy        = (r_state != ptd_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_o_valid;
    assign o_kind      = r_o_kind;
    assign o_out_task  = r_o_task;
    assign o_slice_len = r_o_slice;
    assign o_last      = r_o_last;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt_q    <= ptd_pkg::RT_QUANTUM_RST;
            r_nrt_q   <= ptd_pkg::NRT_QUANTUM_RST;
            r_nrt_pen <= ptd_pkg::NRT_PENALTY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ptd_pkg::CFG_RT_QUANTUM:  r_rt_q    <= i_cfg_data;
                ptd_pkg::CFG_NRT_QUANTUM: r_nrt_q   <= i_cfg_data;
                ptd_pkg::CFG_NRT_PENALTY: r_nrt_pen <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Queue memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        r_rdata <= mem[w_raddr];
    end

    // Will a dispatch follow once the current command's queue work is done
    always_comb begin
        if (r_func == ptd_pkg::FUNC_SLICE_END) begin
            w_disp = !r_run && ((r_cnt[0] != '0) || (r_cnt[1] != '0));
        end else begin
            w_disp = !r_run && (r_cnt[r_act] != '0);
        end
    end

    // Penalty with saturation, and slice of the head entry
    assign w_pen_sum = {1'b0, r_running.pr} + {1'b0, r_nrt_pen};
    assign w_rem     = r_rdata.bt - r_rdata.served;
    assign w_quant   = r_rdata.nrt ? r_nrt_q : r_rt_q;
    assign w_slice   = (w_rem < w_quant) ? w_rem : w_quant;

    // Sequencer: next state, memory control and results
    always_comb begin
        n_state    = r_state;
        n_act      = r_act;
        n_cnt      = r_cnt;
        n_head     = r_head;
        n_run      = r_run;
        n_running  = r_running;
        n_func     = r_func;
        n_ent      = r_ent;
        n_ins_bank = r_ins_bank;
        n_j        = r_j;
        n_has_res  = r_has_res;
        n_res_kind = r_res_kind;
        n_res_task = r_res_task;
        n_o_valid  = 1'b0;
        n_o_kind   = r_o_kind;
        n_o_task   = r_o_task;
        n_o_slice  = r_o_slice;
        n_o_last   = r_o_last;
        w_we       = 1'b0;
        w_waddr    = f_addr(r_ins_bank, r_j, r_head[r_ins_bank]);
        w_wdata    = r_ent;
        w_raddr    = f_addr(r_ins_bank, r_j - CW'(1), r_head[r_ins_bank]);

        case (r_state)
            ptd_pkg::ST_IDLE: begin
                if (start) begin
                    n_func    = i_func;
                    n_has_res = 1'b0;
                    if (i_func == ptd_pkg::FUNC_ARRIVE) begin
                        n_ent.id     = i_task_id;
                        n_ent.pr     = i_priority_req;
                        n_ent.nrt    = i_is_nonrt;
                        n_ent.bt     = i_burst;
                        n_ent.served = '0;
                        if (r_cnt[r_act] == CNT_FULL) begin
                            n_has_res  = 1'b1;
                            n_res_kind = ptd_pkg::KIND_DROPPED;
                            n_res_task = i_task_id;
                            n_state    = ptd_pkg::ST_EMIT;
                        end else begin
                            n_ins_bank = r_act;
                            n_j        = r_cnt[r_act];
                            n_state    = ptd_pkg::ST_INS_RD;
                        end
                    end else if (r_run) begin
                        n_run      = 1'b0;
                        n_has_res  = 1'b1;
                        n_res_task = r_running.id;
                        if (r_running.served < r_running.bt) begin
                            n_ent = r_running;
                            if (r_running.nrt) begin
                                n_ent.pr = w_pen_sum[8] ? 8'hFF : w_pen_sum[7:0];
                            end
                            if (r_cnt[!r_act] == CNT_FULL) begin
                                n_res_kind = ptd_pkg::KIND_DROPPED;
                                n_state    = ptd_pkg::ST_EMIT;
                            end else begin
                                n_res_kind = ptd_pkg::KIND_REQUEUED;
                                n_ins_bank = !r_act;
                                n_j        = r_cnt[!r_act];
                                n_state    = ptd_pkg::ST_INS_RD;
                            end
                        end else begin
                            n_res_kind = ptd_pkg::KIND_FINISHED;
                            n_state    = ptd_pkg::ST_EMIT;
                        end
                    end else begin
                        n_state = ptd_pkg::ST_CHECK;
                    end
                end
            end

            // Walk down from the tail; read slot j-1 or place at the bottom
            ptd_pkg::ST_INS_RD: begin
                if (r_j == '0) begin
                    w_we                = 1'b1;
                    n_cnt[r_ins_bank]   = r_cnt[r_ins_bank] + CW'(1);
                    n_state             = r_has_res ? ptd_pkg::ST_EMIT : ptd_pkg::ST_CHECK;
                end else begin
                    n_state = ptd_pkg::ST_INS_CMP;
                end
            end

            // Shift a higher-priority-value entry up, or drop the new one in
            ptd_pkg::ST_INS_CMP: begin
                w_we = 1'b1;
                if (r_rdata.pr > r_ent.pr) begin
                    w_wdata = r_rdata;
                    n_j     = r_j - CW'(1);
                    n_state = ptd_pkg::ST_INS_RD;
                end else begin
                    n_cnt[r_ins_bank] = r_cnt[r_ins_bank] + CW'(1);
                    n_state           = r_has_res ? ptd_pkg::ST_EMIT : ptd_pkg::ST_CHECK;
                end
            end

            ptd_pkg::ST_EMIT: begin
                n_o_valid = 1'b1;
                n_o_kind  = r_res_kind;
                n_o_task  = r_res_task;
                n_o_slice = '0;
                n_o_last  = !w_disp;
                n_state   = ptd_pkg::ST_CHECK;
            end

            // Swap banks on an empty active queue, then decide on dispatch
            ptd_pkg::ST_CHECK: begin
                if (r_func == ptd_pkg::FUNC_SLICE_END && r_cnt[r_act] == '0
                        && r_cnt[!r_act] != '0) begin
                    n_act = !r_act;
                end
                n_state = w_disp ? ptd_pkg::ST_POP_RD : ptd_pkg::ST_IDLE;
            end

            ptd_pkg::ST_POP_RD: begin
                w_raddr = f_addr(r_act, '0, r_head[r_act]);
                n_state = ptd_pkg::ST_POP_DATA;
            end

            ptd_pkg::ST_POP_DATA: begin
                n_running        = r_rdata;
                n_running.served = r_rdata.served + w_slice;
                n_run            = 1'b1;
                n_cnt[r_act]     = r_cnt[r_act] - CW'(1);
                n_head[r_act]    = (r_head[r_act] == HEAD_LAST) ? '0
                                 : r_head[r_act] + IW'(1);
                n_o_valid        = 1'b1;
                n_o_kind         = ptd_pkg::KIND_DISPATCH;
                n_o_task         = r_rdata.id;
                n_o_slice        = w_slice;
                n_o_last         = 1'b1;
                n_state          = ptd_pkg::ST_IDLE;
            end

            default: n_state = ptd_pkg::ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ptd_pkg::ST_IDLE;
            r_act     <= 1'b0;
            r_cnt[0]  <= '0;
            r_cnt[1]  <= '0;
            r_head[0] <= '0;
            r_head[1] <= '0;
            r_run     <= 1'b0;
            r_running <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_act     <= n_act;
            r_cnt     <= n_cnt;
            r_head    <= n_head;
            r_run     <= n_run;
            r_running <= n_running;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_ent      <= n_ent;
        r_ins_bank <= n_ins_bank;
        r_j        <= n_j;
        r_has_res  <= n_has_res;
        r_res_kind <= n_res_kind;
        r_res_task <= n_res_task;
        r_o_kind   <= n_o_kind;
        r_o_task   <= n_o_task;
        r_o_slice  <= n_o_slice;
        r_o_last   <= n_o_last;
    end

    // Checks
    `include "priority_timeslice_dispatcher_assert.svh"

    `PTD_ASSERT_NOW(a_cnt_bound, 1'b1, (r_cnt[0] <= CNT_FULL) && (r_cnt[1] <= CNT_FULL), "count")
    `PTD_ASSERT_NOW(a_disp_last, o_valid && o_kind == ptd_pkg::KIND_DISPATCH, o_last && r_run, "disp")
    `PTD_ASSERT_NEXT(a_start_busy, start && !busy, busy, "command did not raise busy")
    `PTD_ASSERT_NOW(a_slice_zero, o_valid && o_kind != ptd_pkg::KIND_DISPATCH, o_slice_len == 8'd0, "slice")

endmodule
